FILE: hdl/loco_slot_table_macros.svh
// ----------------------------------------------------------------------------
// loco slot table assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef LOCO_SLOT_TABLE_MACROS_SVH
`define LOCO_SLOT_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// shared types and constants of the locomotive slot table
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 16;
  localparam int unsigned ADDR_W         = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned SLOT_IDX_W     = 4;
  localparam logic [ADDR_W-1:0] FREE_ADDR = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_LOAD   = 2'd2,
    OP_ARM    = 2'd3
  } lst_op_e;

  typedef enum logic [1:0] {
    FK_SPEED = 2'd0,
    FK_LOW   = 2'd1,
    FK_MID   = 2'd2,
    FK_HIGH  = 2'd3
  } lst_kind_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_ALLOC    = 3'd1,
    ST_GUARDED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOMATCH  = 3'd4,
    ST_DONE     = 3'd5
  } lst_status_e;

  // one slot as stored in the table memory
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] speed;
    logic [BYTE_W-1:0] func_low;
    logic [BYTE_W-1:0] func_mid;
    logic [BYTE_W-1:0] func_high;
  } lst_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input beat, restart the scan
    logic scan;    // read the slot at the scan counter
    logic commit;  // apply the decision and load the result register
  } lst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } lst_stat_t;

endpackage

`default_nettype wire

FILE: hdl/loco_slot_table.sv
// ----------------------------------------------------------------------------
// loco_slot_table
// associative table of locomotive slots with allocate on miss
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one command beat: clear,
// update a field in every matching slot, load by address, or arm the
// allocation guard. Output channel (out_valid_o / out_ready_i) returns one
// result beat per command with status and the selected slot contents.
// Every command scans all SLOT_COUNT slots through the table memory read
// port, one slot per cycle, then drains the compare stage and commits.
// The input takes no new beat until the previous command has committed;
// throughput is limited by the single read port.
// Reset frees all slots and clears the guard at once through per-slot
// valid bits; no clearing pass is needed. A stalled receiver holds the
// result register; a finished command waits in its commit step until the
// result register is free, while the input side stays closed.
// ----------------------------------------------------------------------------
`default_nettype none

module loco_slot_table #(
  parameter int unsigned SLOT_COUNT = lst_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic [lst_pkg::ADDR_W-1:0]     loco_address_i,
  input  logic [1:0]                     field_kind_i,
  input  logic [lst_pkg::BYTE_W-1:0]     field_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [lst_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic [lst_pkg::ADDR_W-1:0]     slot_address_o,
  output logic [lst_pkg::BYTE_W-1:0]     speed_out_o,
  output logic [lst_pkg::BYTE_W-1:0]     func_low_out_o,
  output logic [lst_pkg::BYTE_W-1:0]     func_mid_out_o,
  output logic [lst_pkg::BYTE_W-1:0]     func_high_out_o
);
  import lst_pkg::*;

  lst_cmd_t  cmd;
  lst_stat_t stat;

  // sequencer
  lst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // table and result path
  lst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (op_i),
    .loco_address_i  (loco_address_i),
    .field_kind_i    (field_kind_i),
    .field_value_i   (field_value_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .slot_address_o  (slot_address_o),
    .speed_out_o     (speed_out_o),
    .func_low_out_o  (func_low_out_o),
    .func_mid_out_o  (func_mid_out_o),
    .func_high_out_o (func_high_out_o)
  );

endmodule

`default_nettype wire

FILE: hdl/lst_ctrl.sv
// ----------------------------------------------------------------------------
// lst_ctrl
// sequencer for accept, slot scan, decision and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module lst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lst_pkg::lst_cmd_t cmd_o,
  input  lst_pkg::lst_stat_t stat_i
);
  import lst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register can take a new beat
  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/lst_datapath.sv
// ----------------------------------------------------------------------------
// lst_datapath
// slot memory, valid bits, scan compare, guard flag and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lst_datapath #(
  parameter int unsigned SLOT_COUNT = lst_pkg::SLOT_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lst_pkg::lst_cmd_t                    cmd_i,
  output lst_pkg::lst_stat_t                   stat_o,
  input  logic [1:0]                           op_i,
  input  logic [lst_pkg::ADDR_W-1:0]           loco_address_i,
  input  logic [1:0]                           field_kind_i,
  input  logic [lst_pkg::BYTE_W-1:0]           field_value_i,
  output logic [2:0]                           status_o,
  output logic [lst_pkg::SLOT_IDX_W-1:0]       slot_index_o,
  output logic [lst_pkg::ADDR_W-1:0]           slot_address_o,
  output logic [lst_pkg::BYTE_W-1:0]           speed_out_o,
  output logic [lst_pkg::BYTE_W-1:0]           func_low_out_o,
  output logic [lst_pkg::BYTE_W-1:0]           func_mid_out_o,
  output logic [lst_pkg::BYTE_W-1:0]           func_high_out_o
);
  import lst_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // captured beat
  lst_op_e           op_q;
  lst_kind_e         kind_q;
  logic [ADDR_W-1:0] key_q;
  logic [BYTE_W-1:0] val_q;

  // scan pipeline
  logic [IDX_W-1:0]  cnt_q;
  logic              cmp_valid_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  lst_entry_t        rd_data_q;
  logic              rd_valid_q;

  // table storage
  lst_entry_t             mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid_q;

  // scan findings
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  lst_entry_t        hit_entry_q;
  logic              free_q;
  logic [IDX_W-1:0]  free_idx_q;
  logic              any_q;
  logic              guard_q;

  // result register
  lst_status_e            res_status_q;
  logic [SLOT_IDX_W-1:0]  res_idx_q;
  lst_entry_t             res_entry_q;

  lst_entry_t        eff_entry;
  lst_entry_t        upd_entry;
  lst_entry_t        alloc_entry;
  logic              match;
  logic              is_free;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  lst_entry_t        wr_data;
  lst_status_e       res_status;
  logic [IDX_W-1:0]  res_idx;
  lst_entry_t        res_entry;
  logic              do_alloc;

  assign stat_o.scan_last = (cnt_q == LAST_IDX);

  // capture the beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= lst_op_e'(op_i);
      kind_q <= lst_kind_e'(field_kind_i);
      key_q  <= loco_address_i;
      val_q  <= field_value_i;
    end
  end

  // slot as seen by the compare stage, a never-written slot is free and zero
  always_comb begin
    eff_entry      = '0;
    eff_entry.addr = FREE_ADDR;
    if (rd_valid_q) begin
      eff_entry = rd_data_q;
    end
    match   = cmp_valid_q && (eff_entry.addr == key_q);
    is_free = cmp_valid_q && (eff_entry.addr == FREE_ADDR);
  end

  // field replacement for update
  always_comb begin
    upd_entry = eff_entry;
    case (kind_q)
      FK_SPEED: upd_entry.speed     = val_q;
      FK_LOW:   upd_entry.func_low  = val_q;
      FK_MID:   upd_entry.func_mid  = val_q;
      FK_HIGH:  upd_entry.func_high = val_q;
      default:  upd_entry.speed     = val_q;
    endcase
  end

  // decision once the scan is through
  always_comb begin
    alloc_entry      = '0;
    alloc_entry.addr = key_q;
    res_status       = ST_DONE;
    res_idx          = '0;
    res_entry        = '0;
    do_alloc         = 1'b0;
    case (op_q)
      OP_CLEAR: res_status = ST_DONE;
      OP_UPDATE: res_status = any_q ? ST_DONE : ST_NOMATCH;
      OP_LOAD: begin
        if (hit_q) begin
          res_status = ST_HIT;
          res_idx    = hit_idx_q;
          res_entry  = hit_entry_q;
        end else if (guard_q) begin
          res_status = ST_GUARDED;
        end else if (free_q) begin
          res_status = ST_ALLOC;
          res_idx    = free_idx_q;
          res_entry  = alloc_entry;
          do_alloc   = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_ARM: res_status = ST_DONE;
      default: res_status = ST_DONE;
    endcase
  end

  // single write port: update during scan, allocation at commit
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cmp_idx_q;
    wr_data = upd_entry;
    if (match && (op_q == OP_UPDATE)) begin
      wr_en = 1'b1;
    end else if (cmd_i.commit && do_alloc) begin
      wr_en   = 1'b1;
      wr_idx  = free_idx_q;
      wr_data = alloc_entry;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.scan) begin
      rd_data_q <= mem_q[cnt_q];
    end
  end

  // scan control, valid bits, findings and guard
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      rd_valid_q  <= 1'b0;
      valid_q     <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      any_q       <= 1'b0;
      guard_q     <= 1'b0;
    end else begin
      cmp_valid_q <= cmd_i.scan;
      cmp_idx_q   <= cnt_q;
      if (cmd_i.scan) begin
        rd_valid_q <= valid_q[cnt_q];
        cnt_q      <= stat_o.scan_last ? '0 : cnt_q + IDX_W'(1);
      end
      if (cmd_i.load) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        any_q  <= 1'b0;
      end else begin
        if (match) begin
          any_q <= 1'b1;
        end
        if (match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
        if (is_free && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
      if (cmd_i.commit && (op_q == OP_CLEAR)) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.commit && (op_q == OP_ARM)) begin
        guard_q <= 1'b1;
      end else if (cmd_i.commit && (op_q == OP_LOAD) && !hit_q && guard_q) begin
        guard_q <= 1'b0;
      end
    end
  end

  // contents of the first matching slot
  always_ff @(posedge clk_i) begin
    if (match && !hit_q && !cmd_i.load) begin
      hit_entry_q <= eff_entry;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q <= res_status;
      res_idx_q    <= SLOT_IDX_W'(res_idx);
      res_entry_q  <= res_entry;
    end
  end

  assign status_o        = res_status_q;
  assign slot_index_o    = res_idx_q;
  assign slot_address_o  = res_entry_q.addr;
  assign speed_out_o     = res_entry_q.speed;
  assign func_low_out_o  = res_entry_q.func_low;
  assign func_mid_out_o  = res_entry_q.func_mid;
  assign func_high_out_o = res_entry_q.func_high;

endmodule

`default_nettype wire

FILE: hdl/lst_checker.sv
// ----------------------------------------------------------------------------
// lst_checker
// port-level checks of the slot table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "loco_slot_table_macros.svh"

module lst_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [2:0]                     status_o,
  input  logic [lst_pkg::SLOT_IDX_W-1:0] slot_index_o,
  input  logic [lst_pkg::ADDR_W-1:0]     slot_address_o,
  input  logic [lst_pkg::BYTE_W-1:0]     speed_out_o,
  input  logic [lst_pkg::BYTE_W-1:0]     func_low_out_o,
  input  logic [lst_pkg::BYTE_W-1:0]     func_mid_out_o,
  input  logic [lst_pkg::BYTE_W-1:0]     func_high_out_o
);
  import lst_pkg::*;

  logic no_slot;
  logic zero_bytes;

  assign no_slot = (status_o == ST_GUARDED) || (status_o == ST_FULL) ||
                   (status_o == ST_NOMATCH) || (status_o == ST_DONE);
  assign zero_bytes = (speed_out_o == '0) && (func_low_out_o == '0) &&
                      (func_mid_out_o == '0) && (func_high_out_o == '0);

  // one command at a time: the input closes after each beat
  `LST_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "input reopened early")

  // a stalled result beat holds
  `LST_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(slot_address_o), "stalled result changed")

  // results without a slot carry zero slot fields
  `LST_ASSERT_NOW(a_no_slot_zero, out_valid_o && no_slot, (slot_index_o == '0) && (slot_address_o == '0) && zero_bytes, "slot fields not zero")

  // an allocated slot starts with zero contents
  `LST_ASSERT_NOW(a_alloc_zero, out_valid_o && (status_o == ST_ALLOC), zero_bytes, "allocated slot not zeroed")

endmodule

bind loco_slot_table lst_checker u_lst_checker (.*);

`default_nettype wire

FILE: verif/tb_loco_slot_table.sv
// ----------------------------------------------------------------------------
// tb_loco_slot_table
// self-checking bench for the locomotive slot table: command beats go in
// through the valid/ready handshake with random gaps, every result beat is
// checked field by field against a table model updated on each accepted beat
// ----------------------------------------------------------------------------
module tb_loco_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  import lst_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int POOL_SIZE     = 24;
  localparam int RANDOM_CMDS   = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 40;

  // one command as queued for the driver
  typedef struct packed {
    lst_op_e             op;
    logic [ADDR_W-1:0]   addr;
    lst_kind_e           kind;
    logic [BYTE_W-1:0]   value;
    bit                  drain_first;
    bit                  calm;
  } loco_cmd_t;

  // one result beat
  typedef struct packed {
    lst_status_e             status;
    logic [SLOT_IDX_W-1:0]   index;
    logic [ADDR_W-1:0]       addr;
    logic [BYTE_W-1:0]       speed;
    logic [BYTE_W-1:0]       func_low;
    logic [BYTE_W-1:0]       func_mid;
    logic [BYTE_W-1:0]       func_high;
  } slot_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            op_i;
  logic [ADDR_W-1:0]     loco_address_i;
  logic [1:0]            field_kind_i;
  logic [BYTE_W-1:0]     field_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [2:0]            status_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic [ADDR_W-1:0]     slot_address_o;
  logic [BYTE_W-1:0]     speed_out_o;
  logic [BYTE_W-1:0]     func_low_out_o;
  logic [BYTE_W-1:0]     func_mid_out_o;
  logic [BYTE_W-1:0]     func_high_out_o;

  // model of the slot table
  logic [ADDR_W-1:0] tbl_addr      [SLOTS];
  logic [BYTE_W-1:0] tbl_speed     [SLOTS];
  logic [BYTE_W-1:0] tbl_func_low  [SLOTS];
  logic [BYTE_W-1:0] tbl_func_mid  [SLOTS];
  logic [BYTE_W-1:0] tbl_func_high [SLOTS];
  bit                guard_set;

  loco_cmd_t         cmd_queue[$];
  slot_result_t      expected_results[$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  bit in_fire     = 1'b0;
  bit out_fire    = 1'b0;
  bit calm_phase  = 1'b0;
  bit gen_calm    = 1'b0;
  bit drain_next  = 1'b0;
  int send_gap    = 0;
  int take_wait   = 2;
  int cmds_accepted = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int total_cmds    = 0;
  int directed_cmds = 0;
  int status_seen [6];

  loco_slot_table dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .loco_address_i,
    .field_kind_i,
    .field_value_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .slot_index_o,
    .slot_address_o,
    .speed_out_o,
    .func_low_out_o,
    .func_mid_out_o,
    .func_high_out_o
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // table model: applies one command and returns its result beat
  function automatic slot_result_t apply_command(lst_op_e op, logic [ADDR_W-1:0] addr,
                                                 lst_kind_e kind, logic [BYTE_W-1:0] value);
    slot_result_t res;
    int found;
    bit matched;
    res = '0;
    found = -1;
    matched = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_addr[i]      = FREE_ADDR;
          tbl_speed[i]     = '0;
          tbl_func_low[i]  = '0;
          tbl_func_mid[i]  = '0;
          tbl_func_high[i] = '0;
        end
        res.status = ST_DONE;
      end
      OP_UPDATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_addr[i] == addr) begin
            matched = 1'b1;
            case (kind)
              FK_SPEED: tbl_speed[i]     = value;
              FK_LOW:   tbl_func_low[i]  = value;
              FK_MID:   tbl_func_mid[i]  = value;
              default:  tbl_func_high[i] = value;
            endcase
          end
        end
        if (matched) res.status = ST_DONE;
        else res.status = ST_NOMATCH;
      end
      OP_LOAD: begin
        for (int i = 0; i < SLOTS; i++)
          if (found < 0 && tbl_addr[i] == addr) found = i;
        if (found >= 0) begin
          res.status = ST_HIT;
        end else if (guard_set) begin
          // guard eats this miss, nothing allocated
          guard_set = 1'b0;
          res.status = ST_GUARDED;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (found < 0 && tbl_addr[i] == FREE_ADDR) found = i;
          if (found >= 0) begin
            // fresh slot always starts zeroed
            tbl_addr[found]      = addr;
            tbl_speed[found]     = '0;
            tbl_func_low[found]  = '0;
            tbl_func_mid[found]  = '0;
            tbl_func_high[found] = '0;
            res.status = ST_ALLOC;
          end else begin
            res.status = ST_FULL;
          end
        end
        if (found >= 0) begin
          res.index     = found[SLOT_IDX_W-1:0];
          res.addr      = tbl_addr[found];
          res.speed     = tbl_speed[found];
          res.func_low  = tbl_func_low[found];
          res.func_mid  = tbl_func_mid[found];
          res.func_high = tbl_func_high[found];
        end
      end
      default: begin
        guard_set = 1'b1;
        res.status = ST_DONE;
      end
    endcase
    return res;
  endfunction

  function automatic lst_kind_e any_kind();
    return lst_kind_e'($urandom_range(0, 3));
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_cmd(lst_op_e op, logic [ADDR_W-1:0] addr,
                           lst_kind_e kind, logic [BYTE_W-1:0] value);
    loco_cmd_t c;
    c.op          = op;
    c.addr        = addr;
    c.kind        = kind;
    c.value       = value;
    c.drain_first = drain_next || ($urandom_range(0, 49) == 0);
    c.calm        = gen_calm;
    drain_next    = 1'b0;
    cmd_queue.push_back(c);
  endtask

  // monitor: check result beats, predict on command beats
  always @(posedge clk_i) begin
    slot_result_t got;
    slot_result_t want;
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_ni) begin
      // result beat
      if (out_valid_o && out_ready_i) begin
        out_fire      = 1'b1;
        got.status    = lst_status_e'(status_o);
        got.index     = slot_index_o;
        got.addr      = slot_address_o;
        got.speed     = speed_out_o;
        got.func_low  = func_low_out_o;
        got.func_mid  = func_mid_out_o;
        got.func_high = func_high_out_o;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result beat with no command outstanding, status %0d",
                     $time, status_o);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          status_seen[want.status]++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: mismatch on result %0d", $time, results_seen);
              $display("  expected status %0d slot %0d addr %h speed %h func %h %h %h",
                       want.status, want.index, want.addr, want.speed,
                       want.func_low, want.func_mid, want.func_high);
              $display("  actual   status %0d slot %0d addr %h speed %h func %h %h %h",
                       got.status, got.index, got.addr, got.speed,
                       got.func_low, got.func_mid, got.func_high);
            end
          end
        end
      end
      // command beat
      if (in_valid_i && in_ready_o) begin
        in_fire = 1'b1;
        expected_results.push_back(apply_command(lst_op_e'(op_i), loco_address_i,
                                                 lst_kind_e'(field_kind_i),
                                                 field_value_i));
        cmds_accepted++;
      end
    end
  end

  // driver: command side
  always @(negedge clk_i) begin
    loco_cmd_t next_cmd;
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain_first && expected_results.size() != 0)) begin
          next_cmd   = cmd_queue.pop_front();
          calm_phase = next_cmd.calm;
          send_gap   = next_cmd.calm ? 0 : $urandom_range(0, 3);
          in_valid_i     <= 1'b1;
          op_i           <= next_cmd.op;
          loco_address_i <= next_cmd.addr;
          field_kind_i   <= next_cmd.kind;
          field_value_i  <= next_cmd.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // driver: result side, stall counted while a result is waiting
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) take_wait = calm_phase ? 0 : $urandom_range(0, 3);
      if (take_wait > 0) begin
        out_ready_i <= 1'b0;
        if (out_valid_o) take_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [ADDR_W-1:0] a;
    int pick;
    int n;
    int next_phase_at;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = '0;
    loco_address_i = '0;
    field_kind_i   = '0;
    field_value_i  = '0;
    out_ready_i    = 1'b0;
    guard_set      = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_addr[i]      = FREE_ADDR;
      tbl_speed[i]     = '0;
      tbl_func_low[i]  = '0;
      tbl_func_mid[i]  = '0;
      tbl_func_high[i] = '0;
    end
    for (int i = 0; i < 6; i++) status_seen[i] = 0;

    // directed: extremes, every op, free-marker key, guard and clear behavior
    queue_cmd(OP_LOAD,   16'h0000, FK_SPEED, 8'h00);   // miss, allocates slot 0
    queue_cmd(OP_LOAD,   FREE_ADDR, FK_HIGH, 8'hFF);   // free marker hits first free slot
    queue_cmd(OP_UPDATE, 16'h0000, FK_SPEED, 8'hFF);
    queue_cmd(OP_UPDATE, 16'h0000, FK_LOW,   8'hA5);
    queue_cmd(OP_UPDATE, 16'h0000, FK_MID,   8'h5A);
    queue_cmd(OP_UPDATE, 16'h0000, FK_HIGH,  8'h00);
    queue_cmd(OP_LOAD,   16'h0000, FK_SPEED, 8'h00);   // hit with all bytes
    queue_cmd(OP_UPDATE, 16'h1234, FK_SPEED, 8'h11);   // no match
    queue_cmd(OP_UPDATE, FREE_ADDR, FK_SPEED, 8'h77);  // writes every free slot
    queue_cmd(OP_LOAD,   FREE_ADDR, FK_SPEED, 8'h00);  // free slot shows the write
    queue_cmd(OP_LOAD,   16'hFFFE, FK_SPEED, 8'h00);   // allocation zeroes stale bytes
    drain_next = 1'b1;
    queue_cmd(OP_ARM,    16'hFFFF, FK_HIGH,  8'hFF);
    queue_cmd(OP_ARM,    16'h0000, FK_SPEED, 8'h00);   // arm twice
    queue_cmd(OP_LOAD,   16'h0000, FK_SPEED, 8'h00);   // hit keeps the guard
    queue_cmd(OP_LOAD,   16'h4321, FK_SPEED, 8'h00);   // guarded miss
    queue_cmd(OP_LOAD,   16'h4321, FK_SPEED, 8'h00);   // guard gone, allocates
    queue_cmd(OP_ARM,    16'h0000, FK_SPEED, 8'h00);
    queue_cmd(OP_CLEAR,  16'hFFFF, FK_HIGH,  8'hFF);   // clear leaves the guard armed
    queue_cmd(OP_LOAD,   16'h0000, FK_SPEED, 8'h00);   // guarded miss after clear
    queue_cmd(OP_LOAD,   16'h0000, FK_SPEED, 8'h00);
    queue_cmd(OP_UPDATE, 16'h0000, FK_HIGH,  8'hFF);
    queue_cmd(OP_UPDATE, 16'hFFFE, FK_LOW,   8'hFF);   // gone after clear
    directed_cmds = cmd_queue.size();

    // address pool, larger than the table so it overflows now and then
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'($urandom_range(0, 16'hFFFE));
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFE;
    addr_pool[2] = 16'h8000;
    addr_pool[3] = 16'h7FFF;

    // fill the table, overflow it, then a guarded overflow
    drain_next = 1'b1;
    queue_cmd(OP_CLEAR, ADDR_W'($urandom), any_kind(), any_byte());
    for (int i = 0; i < SLOTS; i++) queue_cmd(OP_LOAD, addr_pool[i], any_kind(), any_byte());
    queue_cmd(OP_LOAD, addr_pool[POOL_SIZE-1], any_kind(), any_byte());
    queue_cmd(OP_LOAD, FREE_ADDR, any_kind(), any_byte());
    queue_cmd(OP_ARM, ADDR_W'($urandom), any_kind(), any_byte());
    queue_cmd(OP_LOAD, addr_pool[POOL_SIZE-2], any_kind(), any_byte());

    // random traffic, mostly throttle sessions on pooled addresses
    next_phase_at = cmd_queue.size();
    while (cmd_queue.size() < directed_cmds + RANDOM_CMDS) begin
      if (cmd_queue.size() >= next_phase_at) begin
        gen_calm = ($urandom_range(0, 3) == 0);
        next_phase_at += 40;
      end
      a = addr_pool[$urandom_range(0, POOL_SIZE-1)];
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // select, adjust a few fields, maybe read back
        queue_cmd(OP_LOAD, a, any_kind(), any_byte());
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) queue_cmd(OP_UPDATE, a, any_kind(), any_byte());
        if ($urandom_range(0, 1)) queue_cmd(OP_LOAD, a, any_kind(), any_byte());
      end else if (pick < 65) begin
        // update on a possibly unloaded address
        queue_cmd(OP_UPDATE, a, any_kind(), any_byte());
      end else if (pick < 73) begin
        queue_cmd(OP_ARM, ADDR_W'($urandom), any_kind(), any_byte());
        queue_cmd(OP_LOAD, a, any_kind(), any_byte());
      end else if (pick < 75) begin
        queue_cmd(OP_CLEAR, ADDR_W'($urandom), any_kind(), any_byte());
      end else if (pick < 78) begin
        queue_cmd(lst_op_e'($urandom_range(1, 2)), FREE_ADDR, any_kind(), any_byte());
      end else if (pick < 80) begin
        // burst of selects to push toward a full table
        for (int k = 0; k < SLOTS + 2; k++)
          queue_cmd(OP_LOAD, addr_pool[$urandom_range(0, POOL_SIZE-1)], any_kind(), any_byte());
      end else begin
        // noise on the whole address space
        queue_cmd(lst_op_e'($urandom_range(1, 3)), ADDR_W'($urandom), any_kind(), any_byte());
      end
    end
    total_cmds = cmd_queue.size();

    // reset, released on a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_accepted < total_cmds) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d commands (%0d directed), %0d result beats, %0d failing",
             total_cmds, directed_cmds, results_seen, fail_count);
    $display("result mix: %0d hit, %0d allocated, %0d guarded, %0d full, %0d no match, %0d done",
             status_seen[ST_HIT], status_seen[ST_ALLOC], status_seen[ST_GUARDED],
             status_seen[ST_FULL], status_seen[ST_NOMATCH], status_seen[ST_DONE]);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("watchdog expired with %0d of %0d commands taken, %0d results owed",
             cmds_accepted, total_cmds, expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
